>>> rtl/lhfm_pkg.sv
// Package with shared types and constants for the link health fault monitor.
package lhfm_pkg;

   // Recovery signature length after a successful reconfigure.
   localparam logic [2:0] RECOVERY_TOGGLES = 3'd6;

   // Saturation value of the consecutive fault run.
   localparam logic [7:0] FAIL_RUN_MAX = 8'hff;

   // Reset value of the fault threshold register.
   localparam logic [7:0] FAULT_THRESHOLD_RESET = 8'd3;

   // Snapshot word layout.
   localparam int FRAME_W       = 16;
   localparam int CONNECTED_POS = 16;
   localparam int SUSPENDED_POS = 17;
   localparam int BLOCKED_POS   = 18;
   localparam int FAILURES_POS  = 19;
   localparam int FAILURES_W    = 7;
   localparam int RECONFIGS_POS = 26;
   localparam int RECONFIGS_W   = 6;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_EXPECTED_ID = 2'd0,
      CSR_THRESHOLD   = 2'd1,
      CSR_AUTO_RECFG  = 2'd2
   } csr_index_type;

   // Command codes of an input word.
   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   // Configuration register set.
   typedef struct packed {
      logic [31:0] expected_design_id;
      logic [7:0]  fault_threshold;
      logic        auto_reconfigure;
   } cfg_type;

   // One input word.
   typedef struct packed {
      logic        command;
      logic [31:0] now_time_ms;
      logic        done_pin;
      logic [31:0] ping_answer;
      logic        readback_ok;
      logic        led_handed_over;
      logic [31:0] tx_done_count;
      logic [15:0] write_room;
      logic [15:0] frame_count;
      logic        link_connected;
      logic        link_suspended;
      logic        reconfig_succeeds;
   } req_item_type;

   // One result word.
   typedef struct packed {
      logic [31:0] snapshot_word;
      logic [31:0] uptime_count;
      logic        heartbeat_on;
      logic [2:0]  recovery_left;
      logic        mark_unresponsive;
      logic        request_reconfig;
      logic        tx_stalled;
      logic [31:0] stall_start_ms;
      logic [31:0] frame_change_ms;
      logic [31:0] done_pin_failures;
      logic [31:0] ping_failures;
      logic [31:0] readback_failures;
   } rsp_item_type;

endpackage

>>> rtl/lhfm_core.sv
// Monitor state and the single-pass update for one input word.
module lhfm_core
   import lhfm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic [31:0]          uptime_ff, uptime_in;
   logic                 led_phase_ff, led_phase_in;
   logic [2:0]           recovery_ff, recovery_in;
   logic [31:0]          pin_fail_ff, pin_fail_in;
   logic [31:0]          ping_fail_ff, ping_fail_in;
   logic [31:0]          rb_fail_ff, rb_fail_in;
   logic [FAILURES_W-1:0]  total_fail_ff, total_fail_in;
   logic [7:0]           fail_run_ff, fail_run_in;
   logic [RECONFIGS_W-1:0] reconfig_ff, reconfig_in;
   logic [31:0]          last_tx_ff, last_tx_in;
   logic                 stall_open_ff, stall_open_in;
   logic [31:0]          stall_epoch_ff, stall_epoch_in;
   logic [15:0]          last_frame_ff, last_frame_in;
   logic [31:0]          frame_epoch_ff, frame_epoch_in;
   logic [31:0]          snapshot_ff, snapshot_in;

   logic                 tx_progress;
   logic                 failed;
   logic [7:0]           run_bumped;
   logic                 mark;
   logic                 request;

   // Next state for a tick or a sample.
   always_comb begin
      uptime_in      = uptime_ff;
      led_phase_in   = led_phase_ff;
      recovery_in    = recovery_ff;
      pin_fail_in    = pin_fail_ff;
      ping_fail_in   = ping_fail_ff;
      rb_fail_in     = rb_fail_ff;
      total_fail_in  = total_fail_ff;
      fail_run_in    = fail_run_ff;
      reconfig_in    = reconfig_ff;
      last_tx_in     = last_tx_ff;
      stall_open_in  = stall_open_ff;
      stall_epoch_in = stall_epoch_ff;
      last_frame_in  = last_frame_ff;
      frame_epoch_in = frame_epoch_ff;
      snapshot_in    = snapshot_ff;
      mark           = 1'b0;
      request        = 1'b0;
      tx_progress    = (item.tx_done_count != last_tx_ff);
      failed         = 1'b1;
      run_bumped     = (fail_run_ff == FAIL_RUN_MAX) ? FAIL_RUN_MAX : fail_run_ff + 8'd1;

      if (item.command == CMD_TICK) begin
         // Heartbeat half period: toggle the LED and count down the signature.
         led_phase_in = ~led_phase_ff;
         if (recovery_ff != 3'd0) begin
            recovery_in = recovery_ff - 3'd1;
         end
      end else begin
         uptime_in = uptime_ff + 32'd1;

         // Transmit stall run and frame change stamp.
         if (tx_progress) begin
            last_tx_in = item.tx_done_count;
         end
         if (item.write_room != 16'd0 || tx_progress) begin
            stall_open_in = 1'b0;
         end else if (!stall_open_ff) begin
            stall_open_in  = 1'b1;
            stall_epoch_in = item.now_time_ms;
         end
         if (item.frame_count != last_frame_ff) begin
            last_frame_in  = item.frame_count;
            frame_epoch_in = item.now_time_ms;
         end

         // Companion part checks in priority order, one fault at most.
         if (!item.done_pin) begin
            pin_fail_in = pin_fail_ff + 32'd1;
         end else if (item.ping_answer != cfg.expected_design_id) begin
            ping_fail_in = ping_fail_ff + 32'd1;
         end else if (!item.led_handed_over && !item.readback_ok) begin
            rb_fail_in = rb_fail_ff + 32'd1;
         end else begin
            failed      = 1'b0;
            fail_run_in = 8'd0;
         end

         // Debounce and act on the fault.
         if (failed) begin
            total_fail_in = total_fail_ff + FAILURES_W'(1);
            fail_run_in   = run_bumped;
            if (run_bumped >= cfg.fault_threshold) begin
               mark = 1'b1;
               if (cfg.auto_reconfigure) begin
                  request = 1'b1;
                  if (item.reconfig_succeeds) begin
                     reconfig_in = reconfig_ff + RECONFIGS_W'(1);
                     recovery_in = RECOVERY_TOGGLES;
                     fail_run_in = 8'd0;
                  end
               end
            end
         end

         snapshot_in = {reconfig_in, total_fail_in, (item.write_room == 16'd0),
                        item.link_suspended, item.link_connected, item.frame_count};
      end
   end

   // State registers, updated when a word passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff      <= '0;
         led_phase_ff   <= 1'b1;
         recovery_ff    <= '0;
         pin_fail_ff    <= '0;
         ping_fail_ff   <= '0;
         rb_fail_ff     <= '0;
         total_fail_ff  <= '0;
         fail_run_ff    <= '0;
         reconfig_ff    <= '0;
         last_tx_ff     <= '0;
         stall_open_ff  <= 1'b0;
         stall_epoch_ff <= '0;
         last_frame_ff  <= '0;
         frame_epoch_ff <= '0;
         snapshot_ff    <= '0;
      end else if (step) begin
         uptime_ff      <= uptime_in;
         led_phase_ff   <= led_phase_in;
         recovery_ff    <= recovery_in;
         pin_fail_ff    <= pin_fail_in;
         ping_fail_ff   <= ping_fail_in;
         rb_fail_ff     <= rb_fail_in;
         total_fail_ff  <= total_fail_in;
         fail_run_ff    <= fail_run_in;
         reconfig_ff    <= reconfig_in;
         last_tx_ff     <= last_tx_in;
         stall_open_ff  <= stall_open_in;
         stall_epoch_ff <= stall_epoch_in;
         last_frame_ff  <= last_frame_in;
         frame_epoch_ff <= frame_epoch_in;
         snapshot_ff    <= snapshot_in;
      end
   end

   // Result word built from the updated state.
   always_comb begin
      result.snapshot_word     = snapshot_in;
      result.uptime_count      = uptime_in;
      result.heartbeat_on      = led_phase_in;
      result.recovery_left     = recovery_in;
      result.mark_unresponsive = mark;
      result.request_reconfig  = request;
      result.tx_stalled        = stall_open_in;
      result.stall_start_ms    = stall_epoch_in;
      result.frame_change_ms   = frame_epoch_in;
      result.done_pin_failures = pin_fail_in;
      result.ping_failures     = ping_fail_in;
      result.readback_failures = rb_fail_in;
   end

endmodule

>>> rtl/link_health_fault_monitor_top.sv
// Top level of the link health fault monitor: handshakes, registers and core.
// Each request word is a heartbeat tick or a health sample and yields exactly one
// response word. A word is taken into an input register, processed once the
// response register is free and written to it, so the block sustains one word
// per clock while the receiver keeps rsp_ready high; while a finished response
// waits, an empty input register can still take a new word. Configuration
// writes are taken every cycle and should only be issued while no word is in
// flight.
module link_health_fault_monitor_top
   import lhfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_now_time_ms,
   input  logic        req_done_pin,
   input  logic [31:0] req_ping_answer,
   input  logic        req_readback_ok,
   input  logic        req_led_handed_over,
   input  logic [31:0] req_tx_done_count,
   input  logic [15:0] req_write_room,
   input  logic [15:0] req_frame_count,
   input  logic        req_link_connected,
   input  logic        req_link_suspended,
   input  logic        req_reconfig_succeeds,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_snapshot_word,
   output logic [31:0] rsp_uptime_count,
   output logic        rsp_heartbeat_on,
   output logic [2:0]  rsp_recovery_left,
   output logic        rsp_mark_unresponsive,
   output logic        rsp_request_reconfig,
   output logic        rsp_tx_stalled,
   output logic [31:0] rsp_stall_start_ms,
   output logic [31:0] rsp_frame_change_ms,
   output logic [31:0] rsp_done_pin_failures,
   output logic [31:0] rsp_ping_failures,
   output logic [31:0] rsp_readback_failures
);

   cfg_type      cfg_ff;
   req_item_type item_ff;
   logic         item_valid_ff;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   rsp_item_type result;
   logic         advance;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_design_id <= '0;
         cfg_ff.fault_threshold    <= FAULT_THRESHOLD_RESET;
         cfg_ff.auto_reconfigure   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECTED_ID: cfg_ff.expected_design_id <= csr_data;
            CSR_THRESHOLD:   cfg_ff.fault_threshold    <= csr_data[7:0];
            CSR_AUTO_RECFG:  cfg_ff.auto_reconfigure   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the input word moves on when the response slot is free.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command           <= req_command;
         item_ff.now_time_ms       <= req_now_time_ms;
         item_ff.done_pin          <= req_done_pin;
         item_ff.ping_answer       <= req_ping_answer;
         item_ff.readback_ok       <= req_readback_ok;
         item_ff.led_handed_over   <= req_led_handed_over;
         item_ff.tx_done_count     <= req_tx_done_count;
         item_ff.write_room        <= req_write_room;
         item_ff.frame_count       <= req_frame_count;
         item_ff.link_connected    <= req_link_connected;
         item_ff.link_suspended    <= req_link_suspended;
         item_ff.reconfig_succeeds <= req_reconfig_succeeds;
      end
   end

   // Monitor state and update logic.
   lhfm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_snapshot_word     = rsp_ff.snapshot_word;
   assign rsp_uptime_count      = rsp_ff.uptime_count;
   assign rsp_heartbeat_on      = rsp_ff.heartbeat_on;
   assign rsp_recovery_left     = rsp_ff.recovery_left;
   assign rsp_mark_unresponsive = rsp_ff.mark_unresponsive;
   assign rsp_request_reconfig  = rsp_ff.request_reconfig;
   assign rsp_tx_stalled        = rsp_ff.tx_stalled;
   assign rsp_stall_start_ms    = rsp_ff.stall_start_ms;
   assign rsp_frame_change_ms   = rsp_ff.frame_change_ms;
   assign rsp_done_pin_failures = rsp_ff.done_pin_failures;
   assign rsp_ping_failures     = rsp_ff.ping_failures;
   assign rsp_readback_failures = rsp_ff.readback_failures;

endmodule

>>> dv/link_health_fault_monitor_top_tb.sv
// Self-checking testbench for the link health fault monitor top level.
module link_health_fault_monitor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lhfm_pkg::*;

   // Cycles without any handshake before the run is declared hung.
   localparam int IDLE_LIMIT   = 1000;
   // Cycles allowed after the last response before the block counts as idle.
   localparam int DRAIN_CYCLES = 4;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_BURSTY
   } ready_mode_type;

   // Which check a generated faulty sample trips.
   typedef enum logic [1:0] {
      CAUSE_DONE_PIN,
      CAUSE_PING,
      CAUSE_READBACK
   } fault_cause_type;

   logic        clock = 1'b0;
   logic        reset;

   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   logic        req_valid;
   logic        req_ready;
   logic        req_command;
   logic [31:0] req_now_time_ms;
   logic        req_done_pin;
   logic [31:0] req_ping_answer;
   logic        req_readback_ok;
   logic        req_led_handed_over;
   logic [31:0] req_tx_done_count;
   logic [15:0] req_write_room;
   logic [15:0] req_frame_count;
   logic        req_link_connected;
   logic        req_link_suspended;
   logic        req_reconfig_succeeds;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_snapshot_word;
   logic [31:0] rsp_uptime_count;
   logic        rsp_heartbeat_on;
   logic [2:0]  rsp_recovery_left;
   logic        rsp_mark_unresponsive;
   logic        rsp_request_reconfig;
   logic        rsp_tx_stalled;
   logic [31:0] rsp_stall_start_ms;
   logic [31:0] rsp_frame_change_ms;
   logic [31:0] rsp_done_pin_failures;
   logic [31:0] rsp_ping_failures;
   logic [31:0] rsp_readback_failures;

   link_health_fault_monitor_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_now_time_ms       (req_now_time_ms),
      .req_done_pin          (req_done_pin),
      .req_ping_answer       (req_ping_answer),
      .req_readback_ok       (req_readback_ok),
      .req_led_handed_over   (req_led_handed_over),
      .req_tx_done_count     (req_tx_done_count),
      .req_write_room        (req_write_room),
      .req_frame_count       (req_frame_count),
      .req_link_connected    (req_link_connected),
      .req_link_suspended    (req_link_suspended),
      .req_reconfig_succeeds (req_reconfig_succeeds),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_snapshot_word     (rsp_snapshot_word),
      .rsp_uptime_count      (rsp_uptime_count),
      .rsp_heartbeat_on      (rsp_heartbeat_on),
      .rsp_recovery_left     (rsp_recovery_left),
      .rsp_mark_unresponsive (rsp_mark_unresponsive),
      .rsp_request_reconfig  (rsp_request_reconfig),
      .rsp_tx_stalled        (rsp_tx_stalled),
      .rsp_stall_start_ms    (rsp_stall_start_ms),
      .rsp_frame_change_ms   (rsp_frame_change_ms),
      .rsp_done_pin_failures (rsp_done_pin_failures),
      .rsp_ping_failures     (rsp_ping_failures),
      .rsp_readback_failures (rsp_readback_failures)
   );

   // Free-running clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted monitor state and register copy.
   cfg_type      model_cfg;
   logic [31:0]  up_secs;
   logic         led_on;
   logic [2:0]   recovery_cnt;
   logic [31:0]  pin_fails;
   logic [31:0]  ping_fails;
   logic [31:0]  readback_fails;
   logic [31:0]  total_fails;
   logic [7:0]   fault_run;
   logic [31:0]  reconfigs;
   logic [31:0]  tx_seen;
   logic         stall_active;
   logic [31:0]  stall_epoch_ms;
   logic [15:0]  frame_seen;
   logic [31:0]  frame_epoch_ms;
   logic [31:0]  snapshot;

   rsp_item_type pending_status[$];
   int           mismatch_count = 0;
   int           burst_left = 0;
   logic [31:0]  now_ms = 32'd0;

   // Bring the predicted state to its post-reset values.
   task automatic reset_model();
      model_cfg.expected_design_id = 32'd0;
      model_cfg.fault_threshold    = FAULT_THRESHOLD_RESET;
      model_cfg.auto_reconfigure   = 1'b0;
      up_secs          = '0;
      led_on           = 1'b1;
      recovery_cnt     = '0;
      pin_fails        = '0;
      ping_fails       = '0;
      readback_fails   = '0;
      total_fails      = '0;
      fault_run        = '0;
      reconfigs        = '0;
      tx_seen          = '0;
      stall_active     = 1'b0;
      stall_epoch_ms   = '0;
      frame_seen       = '0;
      frame_epoch_ms   = '0;
      snapshot         = '0;
   endtask

   // Advance the predicted state by one accepted word and return its status.
   function automatic rsp_item_type next_status(input req_item_type w);
      rsp_item_type r;
      logic         tx_progress;
      logic         failed;
      r = '0;
      if (w.command == CMD_TICK) begin
         led_on = ~led_on;
         if (recovery_cnt != 0) begin
            recovery_cnt = recovery_cnt - 3'd1;
         end
      end else begin
         tx_progress = (w.tx_done_count != tx_seen);
         failed      = 1'b1;
         up_secs     = up_secs + 32'd1;
         if (tx_progress) begin
            tx_seen = w.tx_done_count;
         end
         // A stall run needs a full buffer and no transmit progress.
         if (w.write_room != 0 || tx_progress) begin
            stall_active = 1'b0;
         end else if (!stall_active) begin
            stall_active   = 1'b1;
            stall_epoch_ms = w.now_time_ms;
         end
         if (w.frame_count != frame_seen) begin
            frame_seen     = w.frame_count;
            frame_epoch_ms = w.now_time_ms;
         end
         // Only the first failing check in priority order is charged.
         if (!w.done_pin) begin
            pin_fails = pin_fails + 32'd1;
         end else if (w.ping_answer != model_cfg.expected_design_id) begin
            ping_fails = ping_fails + 32'd1;
         end else if (!w.led_handed_over && !w.readback_ok) begin
            readback_fails = readback_fails + 32'd1;
         end else begin
            failed    = 1'b0;
            fault_run = '0;
         end
         // Debounce consecutive faults against the threshold.
         if (failed) begin
            total_fails = total_fails + 32'd1;
            if (fault_run != FAIL_RUN_MAX) begin
               fault_run = fault_run + 8'd1;
            end
            if (fault_run >= model_cfg.fault_threshold) begin
               r.mark_unresponsive = 1'b1;
               if (model_cfg.auto_reconfigure) begin
                  r.request_reconfig = 1'b1;
                  if (w.reconfig_succeeds) begin
                     reconfigs    = reconfigs + 32'd1;
                     recovery_cnt = RECOVERY_TOGGLES;
                     fault_run    = '0;
                  end
               end
            end
         end
         snapshot = {reconfigs[RECONFIGS_W-1:0], total_fails[FAILURES_W-1:0],
                     (w.write_room == 0), w.link_suspended, w.link_connected,
                     w.frame_count};
      end
      r.snapshot_word     = snapshot;
      r.uptime_count      = up_secs;
      r.heartbeat_on      = led_on;
      r.recovery_left     = recovery_cnt;
      r.tx_stalled        = stall_active;
      r.stall_start_ms    = stall_epoch_ms;
      r.frame_change_ms   = frame_epoch_ms;
      r.done_pin_failures = pin_fails;
      r.ping_failures     = ping_fails;
      r.readback_failures = readback_fails;
      return r;
   endfunction

   // A sample that passes every check and leaves transmit and frame unchanged.
   function automatic req_item_type healthy_sample();
      req_item_type w;
      now_ms = now_ms + 32'd1000;
      w = '0;
      w.command        = CMD_SAMPLE;
      w.now_time_ms    = now_ms;
      w.done_pin       = 1'b1;
      w.ping_answer    = model_cfg.expected_design_id;
      w.readback_ok    = 1'b1;
      w.tx_done_count  = tx_seen;
      w.write_room     = 16'd64;
      w.frame_count    = frame_seen;
      w.link_connected = 1'b1;
      return w;
   endfunction

   // A random word; fail_pct sets the share of samples that trip a check.
   function automatic req_item_type random_word(input int fail_pct);
      req_item_type w;
      logic [31:0]  flip;
      int           pick;
      now_ms = now_ms + $urandom_range(900, 1100);
      w.command     = CMD_SAMPLE;
      w.now_time_ms = ($urandom_range(0, 19) == 0) ? $urandom : now_ms;
      w.done_pin    = 1'b1;
      w.ping_answer = model_cfg.expected_design_id;
      w.readback_ok = 1'($urandom_range(0, 1));
      w.led_handed_over = w.readback_ok ? 1'($urandom_range(0, 1)) : 1'b1;
      if ($urandom_range(0, 99) < fail_pct) begin
         flip = $urandom;
         if (flip == 0) begin
            flip = 32'h8000_0001;
         end
         case (fault_cause_type'($urandom_range(0, 2)))
            CAUSE_DONE_PIN: begin
               w.done_pin        = 1'b0;
               w.ping_answer     = $urandom_range(0, 1) ? $urandom : w.ping_answer;
               w.readback_ok     = 1'($urandom_range(0, 1));
               w.led_handed_over = 1'($urandom_range(0, 1));
            end
            CAUSE_PING: begin
               w.ping_answer     = model_cfg.expected_design_id ^ flip;
               w.readback_ok     = 1'($urandom_range(0, 1));
               w.led_handed_over = 1'($urandom_range(0, 1));
            end
            default: begin
               w.readback_ok     = 1'b0;
               w.led_handed_over = 1'b0;
            end
         endcase
      end
      // Transmit count mostly holds so that stall runs can form.
      pick = $urandom_range(0, 9);
      w.tx_done_count = (pick < 6) ? tx_seen : (pick < 9) ? tx_seen + 32'd1 : $urandom;
      pick = $urandom_range(0, 9);
      w.write_room = (pick < 4) ? 16'd0 :
                     (pick < 7) ? 16'($urandom_range(1, 16)) :
                     16'($urandom_range(1, 65535));
      pick = $urandom_range(0, 9);
      w.frame_count = (pick < 5) ? frame_seen : (pick < 9) ? frame_seen + 16'd1 :
                      16'($urandom);
      w.link_connected    = 1'($urandom_range(0, 1));
      w.link_suspended    = 1'($urandom_range(0, 1));
      w.reconfig_succeeds = ($urandom_range(0, 3) != 0);
      // Ticks carry the random payload too, which they must ignore.
      if ($urandom_range(0, 4) == 0) begin
         w.command = CMD_TICK;
      end
      return w;
   endfunction

   // Send one word in bursts with random gaps, then record its expected status.
   task automatic send_word(input req_item_type w);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_command           <= w.command;
      req_now_time_ms       <= w.now_time_ms;
      req_done_pin          <= w.done_pin;
      req_ping_answer       <= w.ping_answer;
      req_readback_ok       <= w.readback_ok;
      req_led_handed_over   <= w.led_handed_over;
      req_tx_done_count     <= w.tx_done_count;
      req_write_room        <= w.write_room;
      req_frame_count       <= w.frame_count;
      req_link_connected    <= w.link_connected;
      req_link_suspended    <= w.link_suspended;
      req_reconfig_succeeds <= w.reconfig_succeeds;
      req_valid             <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(next_status(w));
   endtask

   // Stop sending and wait until every expected status has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; the block must be idle.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_EXPECTED_ID: model_cfg.expected_design_id = data;
         CSR_THRESHOLD:   model_cfg.fault_threshold    = data[7:0];
         CSR_AUTO_RECFG:  model_cfg.auto_reconfigure   = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Field extremes under the reset configuration.
   task automatic test_field_extremes();
      req_item_type w;
      // A tick with an all-ones payload only toggles the heartbeat.
      w = '1;
      w.command = CMD_TICK;
      send_word(w);
      // All-zero sample: done pin fault, stall run opens at time zero.
      w = '0;
      w.command = CMD_SAMPLE;
      send_word(w);
      // All-ones sample: ID fault, transmit moves, frame changes.
      w = '1;
      w.command = CMD_SAMPLE;
      send_word(w);
      // Third straight fault reaches the default threshold; success is ignored.
      w = healthy_sample();
      w.readback_ok       = 1'b0;
      w.reconfig_succeeds = 1'b1;
      send_word(w);
      w = '0;
      w.command = CMD_TICK;
      send_word(w);
      send_word(healthy_sample());
   endtask

   // Check priority, debounce and reconfigure outcome.
   task automatic test_fault_priority();
      req_item_type w;
      wait_idle();
      write_csr(CSR_EXPECTED_ID, 32'hA5C3_3C5A);
      write_csr(CSR_THRESHOLD, 32'd2);
      write_csr(CSR_AUTO_RECFG, 32'd1);
      // Done pin wins even when the ID and readback are bad too.
      w = healthy_sample();
      w.done_pin    = 1'b0;
      w.ping_answer = 32'h0;
      w.readback_ok = 1'b0;
      w.reconfig_succeeds = 1'b1;
      send_word(w);
      // ID fault at the threshold; the reconfigure fails.
      w = healthy_sample();
      w.ping_answer = 32'hA5C3_3C5B;
      w.readback_ok = 1'b0;
      send_word(w);
      // Readback fault past the threshold; the reconfigure succeeds.
      w = healthy_sample();
      w.readback_ok       = 1'b0;
      w.reconfig_succeeds = 1'b1;
      send_word(w);
      // Bad readback is skipped while the LED is handed over.
      w = healthy_sample();
      w.readback_ok     = 1'b0;
      w.led_handed_over = 1'b1;
      send_word(w);
      send_word(healthy_sample());
      // A single fault below the threshold does not act.
      w = healthy_sample();
      w.done_pin          = 1'b0;
      w.reconfig_succeeds = 1'b1;
      send_word(w);
   endtask

   // Recovery toggles count down on ticks and stop at zero.
   task automatic test_recovery_countdown();
      req_item_type w;
      repeat (7) begin
         w = random_word(0);
         w.command = CMD_TICK;
         send_word(w);
      end
   endtask

   // Stall run open, hold, close and reopen, and frame change stamping.
   task automatic test_stall_tracking();
      req_item_type w;
      w = healthy_sample();
      w.write_room = 16'd0;
      send_word(w);
      w = healthy_sample();
      w.write_room = 16'd0;
      send_word(w);
      w = healthy_sample();
      w.write_room    = 16'd0;
      w.tx_done_count = tx_seen + 32'd1;
      send_word(w);
      w = healthy_sample();
      w.write_room = 16'd0;
      send_word(w);
      w = healthy_sample();
      w.write_room  = 16'd1;
      w.frame_count = frame_seen + 16'd1;
      send_word(w);
   endtask

   // A zero threshold acts on every failing sample.
   task automatic test_zero_threshold();
      req_item_type w;
      wait_idle();
      write_csr(CSR_THRESHOLD, 32'd0);
      write_csr(CSR_AUTO_RECFG, 32'd0);
      w = healthy_sample();
      w.done_pin = 1'b0;
      send_word(w);
      send_word(healthy_sample());
      wait_idle();
      write_csr(CSR_AUTO_RECFG, 32'd1);
      w = healthy_sample();
      w.ping_answer       = ~model_cfg.expected_design_id;
      w.reconfig_succeeds = 1'b0;
      send_word(w);
   endtask

   // A long fault run saturates the consecutive count at its maximum.
   task automatic test_fail_run_saturation();
      wait_idle();
      write_csr(CSR_THRESHOLD, {24'($urandom_range(0, 16777215)), 8'hff});
      write_csr(CSR_AUTO_RECFG, {31'($urandom), 1'b0});
      repeat (340) send_word(random_word(100));
      // Enabling reconfigure on a saturated run requests it on the next fault.
      wait_idle();
      write_csr(CSR_AUTO_RECFG, 32'd1);
      repeat (12) send_word(random_word(100));
   endtask

   // Random traffic under a series of register settings.
   task automatic test_random_phases();
      logic [31:0] ident;
      logic [7:0]  thr;
      logic        auto_on;
      int          fail_pct;
      int          count;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               ident = 32'd0; thr = 8'd1; auto_on = 1'b1; fail_pct = 80; count = 150;
            end
            1: begin
               ident = 32'hFFFF_FFFF; thr = 8'hff; auto_on = 1'b0; fail_pct = 30;
               count = 45;
            end
            2: begin
               ident = $urandom; thr = 8'd2; auto_on = 1'b1; fail_pct = 40; count = 45;
            end
            default: begin
               ident = $urandom; thr = 8'($urandom_range(0, 6));
               auto_on = 1'($urandom_range(0, 1)); fail_pct = $urandom_range(10, 70);
               count = 45;
            end
         endcase
         wait_idle();
         write_csr(CSR_EXPECTED_ID, ident);
         write_csr(CSR_THRESHOLD, {24'($urandom), thr});
         write_csr(CSR_AUTO_RECFG, {31'($urandom), auto_on});
         repeat (count) send_word(random_word(fail_pct));
      end
   endtask

   // Receiver stalls on its own pattern, switching mode now and then.
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_mode_left = 0;
   int             ready_count = 0;
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(20, 80);
      end
      ready_mode_left = ready_mode_left - 1;
      ready_count     = ready_count + 1;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_SPARSE: rsp_ready <= (ready_count % 5 == 0);
         default:      rsp_ready <= (ready_count % 20 >= 16);
      endcase
   end

   // Compare one field of a status word.
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Check every accepted status word against the oldest prediction.
   rsp_item_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $error("status word with no prediction pending");
            mismatch_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("snapshot_word", want.snapshot_word, rsp_snapshot_word);
            check_field("uptime_count", want.uptime_count, rsp_uptime_count);
            check_field("heartbeat_on", want.heartbeat_on, rsp_heartbeat_on);
            check_field("recovery_left", want.recovery_left, rsp_recovery_left);
            check_field("mark_unresponsive", want.mark_unresponsive,
                        rsp_mark_unresponsive);
            check_field("request_reconfig", want.request_reconfig, rsp_request_reconfig);
            check_field("tx_stalled", want.tx_stalled, rsp_tx_stalled);
            check_field("stall_start_ms", want.stall_start_ms, rsp_stall_start_ms);
            check_field("frame_change_ms", want.frame_change_ms, rsp_frame_change_ms);
            check_field("done_pin_failures", want.done_pin_failures,
                        rsp_done_pin_failures);
            check_field("ping_failures", want.ping_failures, rsp_ping_failures);
            check_field("readback_failures", want.readback_failures,
                        rsp_readback_failures);
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("link_health_fault_monitor_top: mismatch");
         $finish;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
   end

   // Reset, run the tests in turn and report.
   initial begin
      reset                 = 1'b1;
      csr_valid             = 1'b0;
      csr_index             = CSR_EXPECTED_ID;
      csr_data              = '0;
      req_valid             = 1'b0;
      req_command           = CMD_TICK;
      req_now_time_ms       = '0;
      req_done_pin          = 1'b0;
      req_ping_answer       = '0;
      req_readback_ok       = 1'b0;
      req_led_handed_over   = 1'b0;
      req_tx_done_count     = '0;
      req_write_room        = '0;
      req_frame_count       = '0;
      req_link_connected    = 1'b0;
      req_link_suspended    = 1'b0;
      req_reconfig_succeeds = 1'b0;
      rsp_ready             = 1'b0;
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_fault_priority();
      test_recovery_countdown();
      test_stall_tracking();
      test_zero_threshold();
      test_fail_run_saturation();
      test_random_phases();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("link_health_fault_monitor_top: match");
      end else begin
         $display("link_health_fault_monitor_top: mismatch");
      end
      $finish;
   end

endmodule
